// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Operation codes and transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CMP  = 3'd5,
    OP_NORM = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]                   kind;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic                         equal_flag;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit: fraction add/sub/mul/div with gcd reduction
// Reducing kinds go through a product step, a sum step, ROUNDS*8 steps of the
// 8-cell gcd ring, WORD_BITS division steps, a sign fix and the output load.
// Negate, compare, unused kinds and a zero numerator or denominator go from
// the sum step straight to the output load. One transaction at a time: the
// next is accepted the cycle after the result loads; an output register lets
// the next transaction enter while a result waits.
// Reset clears the sequencer and valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rau_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rau_pkg::out_t       out_data_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned FB    = rau_pkg::FIELD_BITS;
  localparam int unsigned NCELL = 8;
  localparam int unsigned ROUNDS = (2 * W + NCELL - 1) / NCELL + 1;
  localparam int unsigned SW    = $clog2(2 * W + 1);
  localparam int unsigned CW    = $clog2(2 * W + NCELL + 2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_GCD  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  rau_pkg::in_t  in_q;
  logic [W-1:0]  an, ad, bn, bd;
  logic [W-1:0]  m0_q, m1_q, m2_q;
  logic [W-1:0]  p_q, q_q, g_q;
  logic          out_valid_q;
  rau_pkg::out_t out_q;
  logic [W-1:0]  mp, mq, qp, qq;
  logic [W-1:0]  gx [NCELL+1];
  logic [W-1:0]  gy [NCELL+1];
  logic [SW-1:0] gk [NCELL+1];
  logic          ring_load, ring_en, div_load, div_en, gcd_done;
  logic [W-1:0]  np, nq;
  logic [W-1:0]  raw_p, raw_q;
  logic          raw_pass;

  function automatic logic [W-1:0] cut(input logic [FB-1:0] v);
    logic [FB+W-1:0] e;
    e = {{W{v[FB-1]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [FB-1:0] ext(input logic [W-1:0] v);
    logic [FB+W-1:0] e;
    e = {{FB{v[W-1]}}, v};
    return e[FB-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  assign an = cut(in_q.a_num);
  assign ad = cut(in_q.a_den);
  assign bn = cut(in_q.b_num);
  assign bd = cut(in_q.b_den);

  assign in_stall_o = (state_q != S_IDLE);

  // gcd ring: cell 0 takes magnitudes on load, else the tail of the ring
  assign ring_load = (state_q == S_SUM);
  assign ring_en   = ring_load || (state_q == S_GCD);
  assign gx[0] = ring_load ? mag(raw_p) : gx[NCELL];
  assign gy[0] = ring_load ? mag(raw_q) : gy[NCELL];
  assign gk[0] = ring_load ? '0 : gk[NCELL];

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    logic [W-1:0]  xi, yi;
    logic [SW-1:0] ki;
    // the first cell sees the input of the ring, others their neighbor
    assign xi = gx[c];
    assign yi = gy[c];
    assign ki = gk[c];
    rau_gcd_cell #(.W(W), .SW(SW)) u_cell (
      .clk_i (clk_i),
      .en_i  (ring_en),
      .x_i   (xi),
      .y_i   (yi),
      .k_i   (ki),
      .x_o   (gx[c+1]),
      .y_o   (gy[c+1]),
      .k_o   (gk[c+1])
    );
  end

  // the pair sits in the last cell after ROUNDS*NCELL steps
  assign gcd_done = (state_q == S_GCD) && (cnt_q == CW'(ROUNDS * NCELL - 1));

  // two serial dividers share the divisor
  assign div_load = gcd_done;
  assign div_en   = (state_q == S_DIV);

  rau_div_cell #(.W(W)) u_div_p (
    .clk_i (clk_i), .load_i(div_load), .en_i(div_en),
    .dvd_i (mag(p_q)), .dvs_i(g_q), .quo_o(qp)
  );
  rau_div_cell #(.W(W)) u_div_q (
    .clk_i (clk_i), .load_i(div_load), .en_i(div_en),
    .dvd_i (mag(q_q)), .dvs_i(g_q), .quo_o(qq)
  );

  assign mp = p_q[W-1] ? (W'(0) - qp) : qp;
  assign mq = q_q[W-1] ? (W'(0) - qq) : qq;
  assign np = mq[W-1] ? (W'(0) - mp) : mp;
  assign nq = mq[W-1] ? (W'(0) - mq) : mq;

  // form the raw fraction from the products and pick the bypass cases
  always_comb begin
    raw_pass = 1'b0;
    raw_p    = m0_q;
    raw_q    = m2_q;
    unique case (rau_pkg::op_e'(in_q.kind))
      rau_pkg::OP_ADD: raw_p = m0_q + m1_q;
      rau_pkg::OP_SUB: raw_p = m0_q - m1_q;
      rau_pkg::OP_NEG: begin
        raw_p = W'(0) - m0_q; raw_pass = 1'b1;
      end
      rau_pkg::OP_CMP, rau_pkg::OP_NONE: begin
        raw_p = '0; raw_q = W'(1); raw_pass = 1'b1;
      end
      default: raw_p = m0_q;
    endcase
    if (!raw_pass && raw_p == '0) begin
      raw_q = W'(1); raw_pass = 1'b1;
    end else if (!raw_pass && raw_q == '0) begin
      raw_pass = 1'b1;
    end
  end

  // sequence one transaction
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = raw_pass ? S_OUT : S_GCD;
      S_GCD:  if (gcd_done) state_d = S_DIV;
      S_DIV:  if (cnt_q == CW'(W - 1)) state_d = S_FIX;
      S_FIX:  state_d = S_OUT;
      S_OUT:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_GCD && state_d == S_DIV) begin
        cnt_q <= '0;
      end else if (state_q == S_GCD || state_q == S_DIV) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_MUL) begin
      unique case (rau_pkg::op_e'(in_q.kind))
        rau_pkg::OP_MUL: begin
          m0_q <= W'(an * bn); m1_q <= '0;
          m2_q <= W'(ad * bd);
        end
        rau_pkg::OP_DIV: begin
          m0_q <= W'(an * bd); m1_q <= '0;
          m2_q <= W'(ad * bn);
        end
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          m0_q <= W'(an * bd); m1_q <= W'(ad * bn);
          m2_q <= W'(ad * bd);
        end
        default: begin
          m0_q <= an; m1_q <= '0;
          m2_q <= ad;
        end
      endcase
    end
    // hold the raw fraction during reduction
    if (state_q == S_SUM) begin
      p_q <= raw_p;
      q_q <= raw_q;
    end
    if (div_load) begin
      g_q <= (gx[NCELL] == '0) ? W'(1) : (gx[NCELL] << gk[NCELL]);
    end
    if (state_q == S_FIX) begin
      p_q <= np;
      q_q <= nq;
    end
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_q.res_num    <= ext(p_q);
      out_q.res_den    <= ext(q_q);
      out_q.equal_flag <= (rau_pkg::op_e'(in_q.kind) == rau_pkg::OP_CMP) &&
                          (an == bn) && (ad == bd);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rau_gcd_cell.sv =====
// ----------------------------------------------------------------------------
// rau_gcd_cell: one binary gcd step
// Takes a pair (x, y, shift count) and hands the pair after one step on.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [W-1:0]  x_i,
  input  wire logic [W-1:0]  y_i,
  input  wire logic [SW-1:0] k_i,
  output logic      [W-1:0]  x_o,
  output logic      [W-1:0]  y_o,
  output logic      [SW-1:0] k_o
);

  logic [W-1:0]  x_d, y_d;
  logic [SW-1:0] k_d;
  logic [W-1:0]  x_q, y_q;
  logic [SW-1:0] k_q;

  // one step: strip common twos, strip twos of one side, or subtract
  always_comb begin
    x_d = x_i;
    y_d = y_i;
    k_d = k_i;
    if (y_i == '0) begin
      x_d = x_i;
    end else if (x_i == '0) begin
      x_d = y_i;
      y_d = '0;
    end else if (!x_i[0] && !y_i[0]) begin
      x_d = x_i >> 1;
      y_d = y_i >> 1;
      k_d = k_i + SW'(1);
    end else if (!x_i[0]) begin
      x_d = x_i >> 1;
    end else if (!y_i[0]) begin
      y_d = y_i >> 1;
    end else if (x_i >= y_i) begin
      x_d = (x_i - y_i) >> 1;
    end else begin
      y_d = (y_i - x_i) >> 1;
    end
  end

  // advance when the chain is stepping
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      k_q <= k_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign k_o = k_q;

endmodule

`default_nettype wire

// ===== rtl/core/rau_div_cell.sv =====
// ----------------------------------------------------------------------------
// rau_div_cell: serial restoring divider for one dividend
// Shifts a quotient bit into the dividend register per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         load_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] dvd_i,
  input  wire logic [W-1:0] dvs_i,
  output logic      [W-1:0] quo_o
);

  logic [W-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [W:0]   trial;

  // shift, trial subtract, keep bit
  always_comb begin
    trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_i};
    if (!trial[W]) begin
      rem_d = trial[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[W-2:0], quo_q[W-1]};
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
    end else if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the rational arithmetic unit
// Drives fraction transactions with random idling, predicts each result with a
// behavioral gcd reduction and compares every output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam int unsigned WB = 32;
  localparam longint CYCLE_LIMIT = 1500000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  rau_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  rau_pkg::out_t out_data_o;

  rau_pkg::out_t expected_q[$];
  int     mismatch_cnt;
  longint cycle_cnt;
  bit     idle_en;
  bit     hold_rx;
  int     rx_left;

  rational_arith_unit #(.WORD_BITS(WB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Generate the clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Count cycles and end a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [31:0] div_exact(logic [31:0] v, logic [31:0] g);
    logic [31:0] r;
    r = mag32(v) / g;
    return v[31] ? -r : r;
  endfunction

  // Reduce a raw fraction to lowest terms, moving a negative denominator's sign to the numerator
  function automatic rau_pkg::out_t reduce_frac(logic [31:0] p, logic [31:0] q);
    rau_pkg::out_t r;
    logic [31:0] g;
    r = '0;
    if (p == 0) begin
      r.res_den = 1;
    end else if (q == 0) begin
      r.res_num = p;
    end else begin
      g = gcd32(mag32(p), mag32(q));
      if (g == 0) g = 1;
      p = div_exact(p, g);
      q = div_exact(q, g);
      if (q[31]) begin
        p = -p;
        q = -q;
      end
      r.res_num = p;
      r.res_den = q;
    end
    return r;
  endfunction

  function automatic rau_pkg::out_t fraction_result(rau_pkg::in_t t);
    rau_pkg::out_t r;
    logic [31:0] an, ad, bn, bd;
    an = t.a_num; ad = t.a_den; bn = t.b_num; bd = t.b_den;
    r = '0;
    r.res_den = 1;
    case (rau_pkg::op_e'(t.kind))
      rau_pkg::OP_ADD:  r = reduce_frac(an * bd + ad * bn, ad * bd);
      rau_pkg::OP_SUB:  r = reduce_frac(an * bd - ad * bn, ad * bd);
      rau_pkg::OP_MUL:  r = reduce_frac(an * bn, ad * bd);
      rau_pkg::OP_DIV:  r = reduce_frac(an * bd, ad * bn);
      rau_pkg::OP_NEG: begin
        r.res_num = -an;
        r.res_den = ad;
      end
      rau_pkg::OP_CMP:  r.equal_flag = (an == bn) && (ad == bd);
      rau_pkg::OP_NORM: r = reduce_frac(an, ad);
      default: ;
    endcase
    return r;
  endfunction

  // Send one transaction, holding it until accepted
  task automatic send_frac(rau_pkg::op_e k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    rau_pkg::in_t t;
    int gap;
    t.kind = k; t.a_num = an; t.a_den = ad; t.b_num = bn; t.b_den = bd;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(fraction_result(t));
  endtask

  task automatic release_bus();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
      3: return $urandom_range(0, 40) - 20;
      4: return $urandom_range(0, 4000) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  // Receiver stall: random bursts, or a long hold-off while hold_rx is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_left     <= 0;
    end else if (hold_rx) begin
      out_stall_i <= 1'b1;
      rx_left     <= 0;
    end else if (idle_en && rx_left > 0) begin
      out_stall_i <= 1'b1;
      rx_left     <= rx_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      rx_left     <= int'($urandom_range(0, 13));
    end else begin
      out_stall_i <= 1'b0;
      rx_left     <= 0;
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    rau_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("unexpected result: expected none, got %0d/%0d eq=%b",
                   out_data_o.res_num, out_data_o.res_den, out_data_o.equal_flag);
      end else begin
        want = expected_q.pop_front();
        if (want.res_num !== out_data_o.res_num || want.res_den !== out_data_o.res_den
            || want.equal_flag !== out_data_o.equal_flag) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: expected %0d/%0d eq=%b, got %0d/%0d eq=%b",
                     want.res_num, want.res_den, want.equal_flag,
                     out_data_o.res_num, out_data_o.res_den, out_data_o.equal_flag);
        end
      end
    end
  end

  task automatic test_directed();
    send_frac(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_frac(rau_pkg::OP_SUB, 1, 2, 1, 2);
    send_frac(rau_pkg::OP_MUL, -3, 4, 8, -9);
    send_frac(rau_pkg::OP_DIV, 2, 3, 4, 5);
    send_frac(rau_pkg::OP_DIV, 2, 3, 0, 5);
    send_frac(rau_pkg::OP_NEG, 32'h8000_0000, 7, 0, 0);
    send_frac(rau_pkg::OP_NEG, 5, -3, 1, 1);
    send_frac(rau_pkg::OP_CMP, 3, 4, 3, 4);
    send_frac(rau_pkg::OP_CMP, 3, 4, 3, 5);
    send_frac(rau_pkg::OP_NORM, 6, -4, 0, 0);
    send_frac(rau_pkg::OP_NORM, 0, 0, 0, 0);
    send_frac(rau_pkg::OP_NORM, 5, 0, 0, 0);
    send_frac(rau_pkg::OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_frac(rau_pkg::OP_NORM, 1, 32'h8000_0000, 0, 0);
    send_frac(rau_pkg::OP_NORM, 32'h8000_0000, -2, 0, 0);
    send_frac(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 2);
    send_frac(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 1, 1);
    send_frac(rau_pkg::OP_NONE, 1, 2, 3, 4);
    send_frac(rau_pkg::OP_CMP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_frac(rau_pkg::OP_SUB, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
              32'h8000_0000);
  endtask

  task automatic test_random(int n);
    logic [31:0] an, ad;
    for (int i = 0; i < n; i++) begin
      an = rand_word();
      ad = rand_word();
      // Give compare a fair chance of a match
      if ($urandom_range(0, 1))
        send_frac(rau_pkg::op_e'($urandom_range(0, 7)), an, ad, rand_word(), rand_word());
      else
        send_frac(rau_pkg::OP_CMP, an, ad, an, $urandom_range(0, 1) ? ad : rand_word());
    end
  endtask

  // Hold the receiver off while items keep coming so the block backs up
  task automatic test_backpressure();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      test_random(6);
    join
  endtask

  initial begin
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    rst_ni       = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    idle_en      = 1'b1;
    hold_rx      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(900);
    idle_en = 1'b0;
    test_random(180);
    release_bus();

    // Drain outstanding results, then allow for latency
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_gcd_cell.sv
rtl/core/rau_div_cell.sv
rtl/core/rational_arith_unit.sv
test/tb_top.sv
